FILE: rtl/core/ll1pe_pkg.sv
package ll1pe_pkg;

  // table row/column packed as {nonterminal, terminal}
  localparam int ENTRY_W   = 8;
  localparam int ENTRY_CNT = 256;
  localparam int SYM_W     = 5;
  localparam int LEN_W     = 5;
  localparam int SLOT_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_SYMBOL = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;
  localparam logic [1:0] ACT_TOKEN  = 2'd3;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_MATCHED  = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_UNEXP    = 3'd3;
  localparam logic [2:0] ST_NO_RULE  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_LIMIT    = 3'd6;
  localparam logic [2:0] ST_IDLE     = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic               hdr;        // length word rather than a production slot
    logic               valid_bit;
    logic [ENTRY_W-1:0] entry;
    logic [SLOT_W-1:0]  slot;
    logic [SYM_W-1:0]   wdata;
  } tbl_req_t;

endpackage

FILE: rtl/core/ll1pe_table.sv
module ll1pe_table import ll1pe_pkg::*; #(
  parameter int MAX_PROD_LEN = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_req_t         req,
  output logic [SYM_W-1:0] rdata,
  output logic             entry_ok
);

  localparam int SW  = (MAX_PROD_LEN > 1) ? $clog2(MAX_PROD_LEN) : 1;
  localparam int TAW = ENTRY_W + 1 + SW;

  // one word per production slot, plus a length word per entry in the upper half
  logic [SYM_W-1:0]     tmem [2**TAW];
  logic [ENTRY_CNT-1:0] valid_bits;
  logic [TAW-1:0]       addr;

  assign addr     = {req.entry, req.hdr, req.hdr ? {SW{1'b0}} : req.slot[SW-1:0]};
  assign entry_ok = valid_bits[req.entry];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (req.wr_en && req.hdr) begin
      valid_bits[req.entry] <= req.valid_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      tmem[addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= tmem[addr];
    end
  end

endmodule

FILE: rtl/core/ll1pe_ctrl.sv
module ll1pe_ctrl import ll1pe_pkg::*; #(
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_TERMINALS    = 16,
  parameter int MAX_PROD_LEN     = 8,
  parameter int STACK_DEPTH      = 64,
  parameter int MAX_EXPANSIONS   = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [3:0]       nonterminal,
  input  logic [3:0]       terminal,
  input  logic             entry_valid,
  input  logic [3:0]       prod_length,
  input  logic [2:0]       position,
  input  logic [4:0]       symbol,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       status,
  output logic [6:0]       stack_depth,
  output logic [4:0]       top_symbol,
  output logic [6:0]       expansions,
  input  logic [3:0]       start_symbol,
  input  logic [3:0]       end_marker,
  output tbl_req_t         tbl_req,
  input  logic [SYM_W-1:0] tbl_rdata,
  input  logic             tbl_entry_ok
);

  localparam int SW  = (MAX_PROD_LEN > 1) ? $clog2(MAX_PROD_LEN) : 1;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(MAX_EXPANSIONS + 1);
  localparam int XW  = SPW + LEN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_POPRD = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]       state;
  logic [SPW-1:0]   sp;
  logic [SYM_W-1:0] top;
  logic             active;
  logic [3:0]       tok;
  logic [CW-1:0]    cnt;
  logic [SW-1:0]    slot;
  logic             ret_check;
  logic [2:0]       res_status;

  // stack below the top entry; top lives in its own register
  logic [SYM_W-1:0] smem [STACK_DEPTH];
  logic             s_we;
  logic             s_re;
  logic [AW-1:0]    s_waddr;
  logic [AW-1:0]    s_raddr;
  logic [SYM_W-1:0] s_wdata;
  logic [SYM_W-1:0] s_rdata;

  logic             fire;
  logic             in_table;
  logic [LEN_W-1:0] len_clamp;
  logic             rule_ok;
  logic             fits;
  logic [SPW-1:0]   sp_m2;
  logic [SW-1:0]    slot_m1;
  logic [LEN_W-1:0] tlen_m1;
  logic             is_end;

  assign in_ready = (state == S_IDLE);
  assign fire     = in_valid && in_ready;
  assign in_table = (5'(nonterminal) < 5'(NUM_NONTERMINALS)) &&
                    (5'(terminal) < 5'(NUM_TERMINALS));
  assign len_clamp = (5'(prod_length) > 5'(MAX_PROD_LEN)) ? 5'(MAX_PROD_LEN)
                                                          : 5'(prod_length);
  assign rule_ok  = (5'(top[3:0]) < 5'(NUM_NONTERMINALS)) &&
                    (5'(tok) < 5'(NUM_TERMINALS)) && tbl_entry_ok;
  // depth after the top is replaced must not pass the stack size
  assign fits     = (XW'(sp) + XW'(tbl_rdata)) <= XW'(STACK_DEPTH + 1);
  assign sp_m2    = sp - SPW'(2);
  assign slot_m1  = slot - SW'(1);
  assign tlen_m1  = tbl_rdata - LEN_W'(1);
  assign is_end   = (top[3:0] == end_marker);

  always_comb begin
    tbl_req           = '0;
    tbl_req.entry     = {top[3:0], tok};
    tbl_req.valid_bit = entry_valid;
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = sp[AW-1:0];
    s_raddr = sp_m2[AW-1:0];
    s_wdata = tbl_rdata;
    unique case (state)
      S_IDLE: begin
        tbl_req.entry = {nonterminal, terminal};
        tbl_req.hdr   = (action == ACT_HEADER);
        tbl_req.slot  = 4'(position);
        tbl_req.wdata = (action == ACT_HEADER) ? len_clamp : symbol;
        tbl_req.wr_en = fire && in_table &&
                        ((action == ACT_HEADER) ||
                         ((action == ACT_SYMBOL) && (5'(position) < 5'(MAX_PROD_LEN))));
        if (fire && (action == ACT_START)) begin
          s_we    = 1'b1;
          s_waddr = '0;
          s_wdata = {1'b0, end_marker};
        end
      end
      S_CHECK: begin
        tbl_req.rd_en = 1'b1;
        tbl_req.hdr   = 1'b1;
        s_re = (sp > SPW'(1)) && !top[4] && (top == {1'b0, tok});
      end
      S_LEN: begin
        tbl_req.rd_en = fits && (tbl_rdata != '0);
        tbl_req.slot  = 4'(tlen_m1);
        s_re = fits && (tbl_rdata == '0) && (sp > SPW'(1));
      end
      S_PUSH: begin
        tbl_req.rd_en = (slot != '0);
        tbl_req.slot  = 4'(slot_m1);
        s_we = (slot != '0);
      end
      S_POPRD, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // no read ever lands in the cycle of a write to the same entry
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata <= smem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (fire) begin
            cnt <= '0;
            unique case (action)
              ACT_HEADER, ACT_SYMBOL: begin
                res_status <= ST_LOADED;
                state      <= S_EMIT;
              end
              ACT_START: begin
                res_status <= ST_LOADED;
                state      <= S_EMIT;
                top        <= {1'b1, start_symbol};
                sp         <= SPW'(2);
                active     <= 1'b1;
              end
              ACT_TOKEN: begin
                tok <= terminal;
                if (active) begin
                  state <= S_CHECK;
                end else begin
                  res_status <= ST_IDLE;
                  state      <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CHECK: begin
          priority if (sp == '0) begin
            res_status <= ST_UNEXP;
            active     <= 1'b0;
            state      <= S_EMIT;
          end else if (!top[4]) begin
            if (top != {1'b0, tok}) begin
              res_status <= ST_UNEXP;
              active     <= 1'b0;
              state      <= S_EMIT;
            end else begin
              sp         <= sp - SPW'(1);
              res_status <= is_end ? ST_ACCEPTED : ST_MATCHED;
              if (is_end) begin
                active <= 1'b0;
              end
              ret_check <= 1'b0;
              state     <= (sp > SPW'(1)) ? S_POPRD : S_EMIT;
            end
          end else if (!rule_ok) begin
            res_status <= ST_NO_RULE;
            active     <= 1'b0;
            state      <= S_EMIT;
          end else if (cnt >= CW'(MAX_EXPANSIONS)) begin
            res_status <= ST_LIMIT;
            active     <= 1'b0;
            state      <= S_EMIT;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          if (!fits) begin
            res_status <= ST_OVERFLOW;
            active     <= 1'b0;
            state      <= S_EMIT;
          end else begin
            cnt <= cnt + CW'(1);
            sp  <= sp - SPW'(1);
            if (tbl_rdata == '0) begin
              // epsilon: pop and re-examine the new top
              ret_check <= 1'b1;
              state     <= (sp > SPW'(1)) ? S_POPRD : S_CHECK;
            end else begin
              slot  <= SW'(tlen_m1);
              state <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          sp <= sp + SPW'(1);
          if (slot == '0) begin
            top   <= tbl_rdata;
            state <= S_CHECK;
          end else begin
            slot <= slot_m1;
          end
        end
        S_POPRD: begin
          top   <= s_rdata;
          state <= ret_check ? S_CHECK : S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            stack_depth <= 7'(sp);
            top_symbol  <= (sp != '0) ? top : '0;
            expansions  <= 7'(cnt);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/ll1_predictive_parse_engine_unit.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | action nonterminal terminal + load fields
// out     | output    | out_valid / out_ready | status stack_depth top_symbol expansions
// cfg     | input     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// Loads, start and an idle token go straight to S_EMIT. A token passes S_CHECK; each
// production applied adds S_LEN and an S_PUSH per symbol (epsilon pops via S_POPRD
// unless the stack empties), overflow is refused in S_LEN and a match popping onto
// a stored entry passes S_POPRD; the table read port gives one symbol per cycle.
// rst clears the table valid bits, stack pointer and parse state, and sets start symbol 0 and end marker 15.
// A result held by out_ready low blocks the next request only once it is done.
module ll1_predictive_parse_engine_unit import ll1pe_pkg::*; #(
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_TERMINALS    = 16,
  parameter int MAX_PROD_LEN     = 8,
  parameter int STACK_DEPTH      = 64,
  parameter int MAX_EXPANSIONS   = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic [3:0]           nonterminal,
  input  logic [3:0]           terminal,
  input  logic                 entry_valid,
  input  logic [3:0]           prod_length,
  input  logic [2:0]           position,
  input  logic [4:0]           symbol,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [6:0]           stack_depth,
  output logic [4:0]           top_symbol,
  output logic [6:0]           expansions,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]           cfg_data
);

  logic [3:0]       start_symbol;
  logic [3:0]       end_marker;
  tbl_req_t         tbl_req;
  logic [SYM_W-1:0] tbl_rdata;
  logic             tbl_entry_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_symbol <= 4'd0;
      end_marker   <= 4'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_SYMBOL: start_symbol <= cfg_data;
        REG_END_MARKER:   end_marker   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ll1pe_table #(
    .MAX_PROD_LEN (MAX_PROD_LEN)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rdata    (tbl_rdata),
    .entry_ok (tbl_entry_ok)
  );

  ll1pe_ctrl #(
    .NUM_NONTERMINALS (NUM_NONTERMINALS),
    .NUM_TERMINALS    (NUM_TERMINALS),
    .MAX_PROD_LEN     (MAX_PROD_LEN),
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_EXPANSIONS   (MAX_EXPANSIONS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .nonterminal  (nonterminal),
    .terminal     (terminal),
    .entry_valid  (entry_valid),
    .prod_length  (prod_length),
    .position     (position),
    .symbol       (symbol),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .stack_depth  (stack_depth),
    .top_symbol   (top_symbol),
    .expansions   (expansions),
    .start_symbol (start_symbol),
    .end_marker   (end_marker),
    .tbl_req      (tbl_req),
    .tbl_rdata    (tbl_rdata),
    .tbl_entry_ok (tbl_entry_ok)
  );

endmodule

FILE: test/tb_top.sv
module tb_top;
  import ll1pe_pkg::*;

  localparam int T_CNT       = 16;
  localparam int PROD_MAX    = 8;
  localparam int STK_MAX     = 64;
  localparam int EXP_MAX     = 64;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_REQS  = 300;
  localparam int HOLD_CYC    = 400;
  localparam longint TIMEOUT_CYC = 5_000_000;

  typedef struct {
    logic [1:0] act;
    logic [3:0] nt;
    logic [3:0] term;
    logic       ev;
    logic [3:0] len;
    logic [2:0] pos;
    logic [4:0] sym;
  } req_t;

  typedef struct {
    logic [2:0] st;
    logic [6:0] depth;
    logic [4:0] top;
    logic [6:0] nexp;
  } resp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           action = '0;
  logic [3:0]           nonterminal = '0;
  logic [3:0]           terminal = '0;
  logic                 entry_valid = 1'b0;
  logic [3:0]           prod_length = '0;
  logic [2:0]           position = '0;
  logic [4:0]           symbol = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           status;
  logic [6:0]           stack_depth;
  logic [4:0]           top_symbol;
  logic [6:0]           expansions;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [3:0]           cfg_data = '0;

  ll1_predictive_parse_engine_unit u_dut (.*);

  always #5 clk = ~clk;

  // parser state as the block should hold it
  logic       rule_ok  [ENTRY_CNT];
  logic [3:0] rule_len [ENTRY_CNT];
  logic [4:0] rule_sym [ENTRY_CNT*PROD_MAX];
  bit         slot_set [ENTRY_CNT*PROD_MAX];
  logic [4:0] stk [STK_MAX];
  int         sp;
  bit         parsing;
  logic [3:0] start_nt;
  logic [3:0] end_t;

  req_t  parser_reqs[$];
  resp_t awaited_results[$];

  int  send_idle = 28;
  int  recv_idle = 63;
  bit  hold_go = 1'b0;
  bit  holding = 1'b0;
  bit  in_taken = 1'b0;
  int  sent_reqs = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  reg_writes = 0;
  int  outcome_cnt[8];
  req_t  drv_req;
  resp_t want;

  // Expand the stack top until a terminal is exposed, then match it against tok.
  function automatic logic [2:0] expand_and_match(input logic [3:0] tok, output int applied);
    logic [2:0] res;
    logic [4:0] top;
    int e;
    int n;
    bit done;
    applied = 0;
    res = ST_UNEXP;
    done = 1'b0;
    while (!done) begin
      done = 1'b1;
      if (sp == 0) begin
        res = ST_UNEXP;
      end else begin
        top = stk[sp-1];
        e = int'({top[3:0], tok});
        if (!top[4]) begin
          if (top != {1'b0, tok}) begin
            res = ST_UNEXP;
          end else begin
            sp--;
            if (top[3:0] == end_t) begin
              res = ST_ACCEPTED;
              parsing = 1'b0;
            end else begin
              res = ST_MATCHED;
            end
          end
        end else if (!rule_ok[e]) begin
          res = ST_NO_RULE;
        end else if (applied >= EXP_MAX) begin
          res = ST_LIMIT;
        end else if (sp - 1 + int'(rule_len[e]) > STK_MAX) begin
          res = ST_OVERFLOW;
        end else begin
          n = int'(rule_len[e]);
          sp--;
          // rightmost symbol goes in first so the leftmost ends up on top
          for (int i = n - 1; i >= 0; i--) begin
            stk[sp] = rule_sym[e*PROD_MAX + i];
            sp++;
          end
          applied++;
          done = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic void predict_parse_step(input req_t r);
    resp_t x;
    int e;
    int applied;
    e = int'({r.nt, r.term});
    applied = 0;
    x.st = ST_LOADED;
    case (r.act)
      ACT_HEADER: begin
        rule_ok[e]  = r.ev;
        rule_len[e] = (r.len > PROD_MAX) ? 4'(PROD_MAX) : r.len;
      end
      ACT_SYMBOL: begin
        rule_sym[e*PROD_MAX + int'(r.pos)] = r.sym;
      end
      ACT_START: begin
        stk[0]  = {1'b0, end_t};
        stk[1]  = {1'b1, start_nt};
        sp      = 2;
        parsing = 1'b1;
      end
      ACT_TOKEN: begin
        if (!parsing) begin
          x.st = ST_IDLE;
        end else begin
          x.st = expand_and_match(r.term, applied);
          if (x.st >= ST_UNEXP) parsing = 1'b0;
        end
      end
    endcase
    x.depth = 7'(sp);
    x.top   = (sp > 0) ? stk[sp-1] : 5'd0;
    x.nexp  = 7'(applied);
    awaited_results.push_back(x);
  endfunction

  function automatic req_t rand_req(input logic [1:0] act);
    req_t r;
    r.act  = act;
    r.nt   = 4'($urandom_range(0, 15));
    r.term = 4'($urandom_range(0, 15));
    r.ev   = 1'($urandom_range(0, 1));
    r.len  = 4'($urandom_range(0, 15));
    r.pos  = 3'($urandom_range(0, 7));
    r.sym  = 5'($urandom_range(0, 31));
    return r;
  endfunction

  function automatic req_t mk_req(input logic [1:0] act, input logic [3:0] nt,
                                  input logic [3:0] term, input logic ev,
                                  input logic [3:0] len, input logic [2:0] pos,
                                  input logic [4:0] sym);
    req_t r;
    r.act  = act;
    r.nt   = nt;
    r.term = term;
    r.ev   = ev;
    r.len  = len;
    r.pos  = pos;
    r.sym  = sym;
    return r;
  endfunction

  // A rule is only switched on once every slot it will read has been loaded.
  function automatic void queue_req(input req_t r);
    req_t fill;
    int e;
    int n;
    e = int'({r.nt, r.term});
    n = (r.len > PROD_MAX) ? PROD_MAX : int'(r.len);
    if (r.act == ACT_HEADER && r.ev) begin
      for (int p = 0; p < n; p++) begin
        if (!slot_set[e*PROD_MAX + p]) begin
          fill      = rand_req(ACT_SYMBOL);
          fill.nt   = r.nt;
          fill.term = r.term;
          fill.pos  = 3'(p);
          slot_set[e*PROD_MAX + p] = 1'b1;
          predict_parse_step(fill);
          parser_reqs.push_back(fill);
          sent_reqs++;
        end
      end
    end
    if (r.act == ACT_SYMBOL) slot_set[e*PROD_MAX + int'(r.pos)] = 1'b1;
    predict_parse_step(r);
    parser_reqs.push_back(r);
    sent_reqs++;
  endfunction

  function automatic logic [3:0] pick_nt();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return $urandom_range(0, 1) ? start_nt : 4'($urandom_range(0, 3));
  endfunction

  // Try every terminal on a scratch copy of the stack; prefer one that matches.
  function automatic logic [3:0] pick_good_token();
    logic [4:0] saved_stk [STK_MAX];
    int saved_sp;
    int applied;
    int base;
    bit saved_run;
    bit have_acc;
    logic [2:0] st;
    logic [3:0] t;
    logic [3:0] acc_t;
    saved_stk = stk;
    saved_sp  = sp;
    saved_run = parsing;
    base      = $urandom_range(0, 15);
    have_acc  = 1'b0;
    acc_t     = 4'(base);
    for (int k = 0; k < T_CNT; k++) begin
      t  = 4'(base + k);
      st = expand_and_match(t, applied);
      stk = saved_stk;
      sp = saved_sp;
      parsing = saved_run;
      if (st == ST_MATCHED) return t;
      if (st == ST_ACCEPTED && !have_acc) begin
        have_acc = 1'b1;
        acc_t    = t;
      end
    end
    return acc_t;
  endfunction

  function automatic void add_rules(input int cnt);
    req_t r;
    req_t s;
    int n;
    for (int k = 0; k < cnt; k++) begin
      r    = rand_req(ACT_HEADER);
      r.nt = pick_nt();
      r.ev = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) < 7) r.len = 4'($urandom_range(0, 3));
      else if ($urandom_range(0, 5) == 0) r.len = 4'($urandom_range(9, 15));
      else r.len = 4'($urandom_range(4, 8));
      n = (r.len > PROD_MAX) ? PROD_MAX : int'(r.len);
      for (int p = 0; p < n; p++) begin
        s      = rand_req(ACT_SYMBOL);
        s.nt   = r.nt;
        s.term = r.term;
        s.pos  = 3'(p);
        if ($urandom_range(0, 99) < 65) s.sym = {1'b0, 4'($urandom_range(0, 15))};
        else s.sym = {1'b1, pick_nt()};
        queue_req(s);
      end
      queue_req(r);
    end
  endfunction

  function automatic void parse_session();
    req_t r;
    int toks;
    queue_req(rand_req(ACT_START));
    toks = $urandom_range(1, 16);
    for (int k = 0; k < toks && parsing; k++) begin
      r = rand_req(ACT_TOKEN);
      if ($urandom_range(0, 99) < 88) r.term = pick_good_token();
      queue_req(r);
    end
    if (!parsing && $urandom_range(0, 3) == 0) queue_req(rand_req(ACT_TOKEN));
  endfunction

  function automatic void fill_random_phase(input int goal);
    int target;
    int roll;
    target = sent_reqs + goal;
    while (sent_reqs < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 18) add_rules($urandom_range(1, 4));
      else if (roll < 28) queue_req(rand_req(2'($urandom_range(0, 3))));
      else parse_session();
    end
  endfunction

  task automatic wait_drained();
    while (parser_reqs.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    if (idx == REG_START_SYMBOL) start_nt = val;
    else end_t = val;
    reg_writes++;
  endtask

  // request driver
  always @(posedge clk) in_taken <= in_valid && in_ready;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (parser_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        drv_req = parser_reqs.pop_front();
        action      <= drv_req.act;
        nonterminal <= drv_req.nt;
        terminal    <= drv_req.term;
        entry_valid <= drv_req.ev;
        prod_length <= drv_req.len;
        position    <= drv_req.pos;
        symbol      <= drv_req.sym;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !holding && ($urandom_range(0, 99) >= recv_idle);
  end

  // long receiver stall so the block backs up onto its request side
  initial begin
    wait (hold_go);
    @(posedge clk) holding <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d with no request outstanding: status %0d depth %0d",
                   results_seen, status, stack_depth);
      end else begin
        want = awaited_results.pop_front();
        outcome_cnt[want.st]++;
        if (status !== want.st || stack_depth !== want.depth ||
            top_symbol !== want.top || expansions !== want.nexp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("ERROR: result %0d expected status %0d depth %0d top 0x%0h exp %0d,",
                   results_seen, want.st, want.depth, want.top, want.nexp);
            $display(" got status %0d depth %0d top 0x%0h exp %0d",
                     status, stack_depth, top_symbol, expansions);
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYC * 10);
    $display("ERROR: timed out with %0d results outstanding", awaited_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [3:0] cfg_s;
    logic [3:0] cfg_e;
    for (int i = 0; i < ENTRY_CNT; i++) rule_ok[i] = 1'b0;
    for (int i = 0; i < ENTRY_CNT*PROD_MAX; i++) slot_set[i] = 1'b0;
    for (int i = 0; i < 8; i++) outcome_cnt[i] = 0;
    sp       = 0;
    parsing  = 1'b0;
    start_nt = 4'd0;
    end_t    = 4'd15;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // token before any start, then epsilon rule straight into accept
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd15, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_HEADER, 4'd0, 4'd15, 1'b1, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_START, 4'd0, 4'd0, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd15, 1'b0, 4'd0, 3'd0, 5'd0));
    wait_drained();
    write_reg(REG_START_SYMBOL, 4'd1);

    // N1 -> N1 x8 with an oversized length: grows until the stack overflows
    for (int p = 0; p < PROD_MAX; p++)
      queue_req(mk_req(ACT_SYMBOL, 4'd1, 4'd2, 1'b0, 4'd0, 3'(p), 5'h11));
    queue_req(mk_req(ACT_HEADER, 4'd1, 4'd2, 1'b1, 4'd15, 3'd0, 5'd0));
    queue_req(mk_req(ACT_START, 4'd0, 4'd0, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd2, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd2, 1'b0, 4'd0, 3'd0, 5'd0));
    // N1 -> N1 loops until the expansion limit
    queue_req(mk_req(ACT_SYMBOL, 4'd1, 4'd3, 1'b0, 4'd0, 3'd0, 5'h11));
    queue_req(mk_req(ACT_HEADER, 4'd1, 4'd3, 1'b1, 4'd1, 3'd0, 5'd0));
    queue_req(mk_req(ACT_START, 4'd0, 4'd0, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd3, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_START, 4'd0, 4'd0, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd0, 1'b0, 4'd0, 3'd0, 5'd0));
    // rule loaded mid-parse; end marker then moved so the bottom pops as a plain match
    queue_req(mk_req(ACT_START, 4'd0, 4'd0, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_HEADER, 4'd1, 4'd15, 1'b1, 4'd0, 3'd0, 5'd0));
    wait_drained();
    write_reg(REG_END_MARKER, 4'd4);
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd15, 1'b0, 4'd0, 3'd0, 5'd0));
    queue_req(mk_req(ACT_TOKEN, 4'd0, 4'd7, 1'b0, 4'd0, 3'd0, 5'd0));
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin cfg_s = 4'd0;  cfg_e = 4'd15; end
        1: begin cfg_s = 4'd15; cfg_e = 4'd0;  end
        3: begin cfg_s = 4'd15; cfg_e = 4'd15; end
        4: begin cfg_s = 4'd0;  cfg_e = 4'd0;  end
        default: begin
          cfg_s = 4'($urandom_range(0, 15));
          cfg_e = 4'($urandom_range(0, 15));
        end
      endcase
      write_reg(REG_START_SYMBOL, cfg_s);
      write_reg(REG_END_MARKER, cfg_e);
      send_idle = (ph < 2) ? 28 : (ph < 4) ? 63 : 0;
      recv_idle = (ph < 2) ? 63 : (ph < 4) ? 28 : 0;
      @(posedge clk);
      fill_random_phase(PHASE_REQS);
      if (ph == 0) hold_go = 1'b1;
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("Ran %0d requests with %0d register writes over %0d random phases",
             sent_reqs, reg_writes, RAND_PHASES);
    $write("Outcomes: loaded %0d matched %0d accepted %0d unexpected %0d",
           outcome_cnt[ST_LOADED], outcome_cnt[ST_MATCHED], outcome_cnt[ST_ACCEPTED],
           outcome_cnt[ST_UNEXP]);
    $display(" no-rule %0d overflow %0d limit %0d idle %0d, mismatches %0d",
             outcome_cnt[ST_NO_RULE], outcome_cnt[ST_OVERFLOW],
             outcome_cnt[ST_LIMIT], outcome_cnt[ST_IDLE], mismatches);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: ll1_predictive_parse_engine_unit.f
rtl/core/ll1pe_pkg.sv
rtl/core/ll1pe_table.sv
rtl/core/ll1pe_ctrl.sv
rtl/core/ll1_predictive_parse_engine_unit.sv
test/tb_top.sv
